/* design/bum_pkg.sv */
// shared widths, action codes and register indexes for the button uid modifier
`default_nettype none
package bum_pkg;
	localparam int MODE_W = 3;
	localparam int LEN_W = 4;
	localparam int POS_W = 4;
	localparam int BYTE_W = 8;
	localparam int RLO_W = 64;
	localparam int RHI_W = 16;
	localparam int CFG_DATA_W = 4;

	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [LEN_W-1:0] len_t;
	typedef logic [0:0] cfg_idx_t;

	localparam mode_t ACT_NONE = 3'd0;
	localparam mode_t ACT_RANDOM = 3'd1;
	localparam mode_t ACT_LEFT_INC = 3'd2;
	localparam mode_t ACT_RIGHT_INC = 3'd3;
	localparam mode_t ACT_LEFT_DEC = 3'd4;
	localparam mode_t ACT_RIGHT_DEC = 3'd5;
	localparam mode_t ACT_CYCLE = 3'd6;

	localparam cfg_idx_t CFG_MODE = 1'b0;
	localparam cfg_idx_t CFG_LEN = 1'b1;

	localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
endpackage
`default_nettype wire

/* design/bum_if.sv */
// valid/ready channel interfaces for input items and uid results
`default_nettype none
interface bum_in_if import bum_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic pin_level;
	logic [POS_W-1:0] load_index;
	logic [BYTE_W-1:0] load_value;
	logic [RLO_W-1:0] random_low;
	logic [RHI_W-1:0] random_high;

	modport source (output valid, kind, pin_level, load_index, load_value, random_low,
		random_high, input ready);
	modport sink (input valid, kind, pin_level, load_index, load_value, random_low,
		random_high, output ready);
endinterface

interface bum_out_if import bum_pkg::*; ();
	logic valid;
	logic ready;
	logic [POS_W-1:0] uid_position;
	logic [BYTE_W-1:0] uid_byte;
	logic cycle_request;
	logic last;

	modport source (output valid, uid_position, uid_byte, cycle_request, last, input ready);
	modport sink (input valid, uid_position, uid_byte, cycle_request, last, output ready);
endinterface
`default_nettype wire

/* design/button_uid_modifier_top.sv */
// items are taken only in idle with the output register free; a load writes the uid store as it is taken
// throughput: random and left inc/dec walk one uid byte per cycle while results are taken
// right inc/dec run a descending carry pass first, then walk the bytes in ascending order
// a settings cycle request is registered straight from the press; a stalled result holds the byte walk
// reset clears the uid store, the press history and the output register, mode 0, length 4
`default_nettype none
module button_uid_modifier_top import bum_pkg::*; #(
	parameter int UID_BYTES = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	bum_in_if.sink items,
	bum_out_if.source results,
	input wire logic cfg_we,
	input wire cfg_idx_t cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int IDX_W = $clog2(UID_BYTES);
	localparam int RND_W = BYTE_W * UID_BYTES;

	typedef enum logic [1:0] {ST_IDLE, ST_CARRY, ST_EMIT} state_t;
	typedef enum logic [1:0] {OP_PLAIN, OP_RAND, OP_INC, OP_DEC} op_t;

	state_t state_q;
	op_t op_q;
	mode_t mode_q;
	len_t len_q;
	logic was_pressed_q;
	logic [BYTE_W-1:0] uid_q [UID_BYTES];
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] lst_q;
	logic carry_q;
	logic [RND_W-1:0] rnd_q;
	logic out_valid_q;
	logic [POS_W-1:0] out_pos_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic out_cyc_q;
	logic out_last_q;

	logic out_free;
	logic pressed;
	logic press;
	len_t n_used;
	logic [IDX_W-1:0] lst_w;
	logic [BYTE_W-1:0] cur_byte;
	logic [BYTE_W-1:0] new_byte;
	logic carry_nx;
	logic [RLO_W+RHI_W-1:0] rnd_all;

	assign out_free = !out_valid_q || results.ready;
	assign items.ready = (state_q == ST_IDLE) && out_free;
	assign pressed = !items.pin_level;
	assign press = pressed && !was_pressed_q;
	assign rnd_all = {items.random_high, items.random_low};
	assign cur_byte = uid_q[idx_q];

	always_comb begin
		if (len_q == '0) begin
			n_used = len_t'(1);
		end else if (len_q > len_t'(UID_BYTES)) begin
			n_used = len_t'(UID_BYTES);
		end else begin
			n_used = len_q;
		end
		lst_w = IDX_W'(n_used - len_t'(1));
	end

	// one byte of the carry or borrow chain, or the next random byte
	always_comb begin
		new_byte = cur_byte;
		carry_nx = 1'b0;
		case (op_q)
			OP_RAND: new_byte = rnd_q[BYTE_W-1:0];
			OP_INC: begin
				new_byte = cur_byte + BYTE_W'(carry_q);
				carry_nx = carry_q && (cur_byte == BYTE_ONES);
			end
			OP_DEC: begin
				new_byte = cur_byte - BYTE_W'(carry_q);
				carry_nx = carry_q && (cur_byte == BYTE_ZERO);
			end
			default: new_byte = cur_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_PLAIN;
			mode_q <= ACT_NONE;
			len_q <= len_t'(4);
			was_pressed_q <= 1'b0;
			for (int i = 0; i < UID_BYTES; i++) begin
				uid_q[i] <= BYTE_ZERO;
			end
			idx_q <= '0;
			lst_q <= '0;
			carry_q <= 1'b0;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
			out_pos_q <= '0;
			out_byte_q <= '0;
			out_cyc_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MODE: mode_q <= cfg_data[MODE_W-1:0];
					CFG_LEN: len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (items.valid && items.ready) begin
						if (items.kind) begin
							if (items.load_index < POS_W'(UID_BYTES)) begin
								uid_q[items.load_index[IDX_W-1:0]] <= items.load_value;
							end
						end else begin
							was_pressed_q <= pressed;
							if (press) begin
								idx_q <= '0;
								lst_q <= lst_w;
								carry_q <= 1'b1;
								rnd_q <= rnd_all[RND_W-1:0];
								case (mode_q)
									ACT_RANDOM: begin
										op_q <= OP_RAND;
										state_q <= ST_EMIT;
									end
									ACT_LEFT_INC: begin
										op_q <= OP_INC;
										state_q <= ST_EMIT;
									end
									ACT_LEFT_DEC: begin
										op_q <= OP_DEC;
										state_q <= ST_EMIT;
									end
									ACT_RIGHT_INC: begin
										op_q <= OP_INC;
										idx_q <= lst_w;
										state_q <= ST_CARRY;
									end
									ACT_RIGHT_DEC: begin
										op_q <= OP_DEC;
										idx_q <= lst_w;
										state_q <= ST_CARRY;
									end
									ACT_CYCLE: begin
										out_valid_q <= 1'b1;
										out_pos_q <= '0;
										out_byte_q <= BYTE_ZERO;
										out_cyc_q <= 1'b1;
										out_last_q <= 1'b1;
									end
									default: ;
								endcase
							end
						end
					end
				end
				ST_CARRY: begin
					// descending pass, results follow in ascending order
					uid_q[idx_q] <= new_byte;
					carry_q <= carry_nx;
					if (idx_q == '0) begin
						op_q <= OP_PLAIN;
						state_q <= ST_EMIT;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						uid_q[idx_q] <= new_byte;
						carry_q <= carry_nx;
						rnd_q <= {BYTE_ZERO, rnd_q[RND_W-1:BYTE_W]};
						out_valid_q <= 1'b1;
						out_pos_q <= POS_W'(idx_q);
						out_byte_q <= new_byte;
						out_cyc_q <= 1'b0;
						out_last_q <= (idx_q == lst_q);
						if (idx_q == lst_q) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign results.valid = out_valid_q;
	assign results.uid_position = out_pos_q;
	assign results.uid_byte = out_byte_q;
	assign results.cycle_request = out_cyc_q;
	assign results.last = out_last_q;

	a_cycle_result: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && !items.kind && !items.pin_level && !was_pressed_q
			&& mode_q == ACT_CYCLE)
		|=> (results.valid && results.cycle_request && results.last))
		else $error("settings cycle press gave no request");

	a_cycle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.cycle_request)
		|-> (results.uid_position == '0 && results.uid_byte == BYTE_ZERO && results.last))
		else $error("settings cycle result carries uid fields");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.cycle_request)
		|-> (results.uid_position <= POS_W'(lst_q)))
		else $error("uid result beyond length in use");

	a_carry_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CARRY) |-> (op_q == OP_INC || op_q == OP_DEC))
		else $error("carry pass without inc or dec");

	a_emit_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_free && idx_q == lst_q)
		|=> (state_q == ST_IDLE && results.last))
		else $error("byte walk did not end on last byte");
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// testbench for the button uid modifier: directed and random traffic checked by a local uid predictor
module tb_top import bum_pkg::*; ();

	localparam int UID_BYTES = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 35;
	localparam mode_t ACT_UNUSED = 3'd7;
	localparam logic KIND_TICK = 1'b0;
	localparam logic KIND_LOAD = 1'b1;
	localparam logic PIN_PRESSED = 1'b0;
	localparam logic PIN_RELEASED = 1'b1;

	typedef struct packed {
		logic kind;
		logic pin_level;
		logic [POS_W-1:0] load_index;
		logic [BYTE_W-1:0] load_value;
		logic [RLO_W-1:0] random_low;
		logic [RHI_W-1:0] random_high;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [BYTE_W-1:0] data;
		logic cycle_req;
		logic last;
	} uid_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bum_in_if items();
	bum_out_if results();

	button_uid_modifier_top #(.UID_BYTES(UID_BYTES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items),
		.results(results),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	mode_t act_mode;
	len_t uid_len;
	logic btn_held;
	logic [BYTE_W-1:0] uid_copy [UID_BYTES];
	uid_result_t pending_uid [$];

	int err_count = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		err_count++;
	endtask

	task automatic predict_uid(input item_t it);
		int n;
		int idx;
		logic carry;
		logic down;
		logic press;
		if (it.kind == KIND_LOAD) begin
			if (it.load_index < UID_BYTES) uid_copy[it.load_index] = it.load_value;
			return;
		end
		press = (it.pin_level == PIN_PRESSED) && !btn_held;
		btn_held = (it.pin_level == PIN_PRESSED);
		if (!press) return;
		n = (uid_len == 0) ? 1 : (uid_len > UID_BYTES) ? UID_BYTES : int'(uid_len);
		down = (act_mode == ACT_LEFT_DEC) || (act_mode == ACT_RIGHT_DEC);
		case (act_mode)
			ACT_RANDOM: begin
				for (int i = 0; i < n; i++)
					uid_copy[i] = (i < 8) ? it.random_low[8*i +: 8] : it.random_high[8*(i-8) +: 8];
			end
			ACT_LEFT_INC, ACT_LEFT_DEC, ACT_RIGHT_INC, ACT_RIGHT_DEC: begin
				carry = 1'b1;
				for (int k = 0; k < n; k++) begin
					// right forms walk from the last byte in use toward byte 0
					idx = (act_mode == ACT_RIGHT_INC || act_mode == ACT_RIGHT_DEC) ? n - 1 - k : k;
					if (carry) begin
						carry = down ? (uid_copy[idx] == BYTE_ZERO) : (uid_copy[idx] == BYTE_ONES);
						uid_copy[idx] = down ? uid_copy[idx] - 8'd1 : uid_copy[idx] + 8'd1;
					end
				end
			end
			ACT_CYCLE: begin
				pending_uid.push_back({POS_W'(0), BYTE_ZERO, 1'b1, 1'b1});
				return;
			end
			default: begin
				return;
			end
		endcase
		for (int i = 0; i < n; i++)
			pending_uid.push_back({POS_W'(i), uid_copy[i], 1'b0, (i == n - 1)});
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.kind = 1'($urandom_range(0, 1));
		it.pin_level = 1'($urandom_range(0, 1));
		it.load_index = POS_W'($urandom_range(0, 15));
		it.load_value = BYTE_W'($urandom_range(0, 255));
		it.random_low = {$urandom(), $urandom()};
		it.random_high = RHI_W'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid <= 1'b1;
		items.kind <= it.kind;
		items.pin_level <= it.pin_level;
		items.load_index <= it.load_index;
		items.load_value <= it.load_value;
		items.random_low <= it.random_low;
		items.random_high <= it.random_high;
		do @(posedge clk); while (items.ready !== 1'b1);
		predict_uid(it);
	endtask

	task automatic send_tick(input logic pin, input logic [RLO_W-1:0] rlo,
		input logic [RHI_W-1:0] rhi);
		item_t it;
		it = rand_item();
		it.kind = KIND_TICK;
		it.pin_level = pin;
		it.random_low = rlo;
		it.random_high = rhi;
		send_item(it);
	endtask

	task automatic send_load(input logic [POS_W-1:0] idx, input logic [BYTE_W-1:0] val);
		item_t it;
		it = rand_item();
		it.kind = KIND_LOAD;
		it.load_index = idx;
		it.load_value = val;
		send_item(it);
	endtask

	// release then press, so the second tick is a new press
	task automatic press_button(input logic [RLO_W-1:0] rlo, input logic [RHI_W-1:0] rhi);
		send_tick(PIN_RELEASED, {$urandom(), $urandom()}, RHI_W'($urandom_range(0, 65535)));
		send_tick(PIN_PRESSED, rlo, rhi);
	endtask

	task automatic settle();
		items.valid <= 1'b0;
		while (pending_uid.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE) act_mode = val[MODE_W-1:0];
		else uid_len = val[LEN_W-1:0];
	endtask

	task automatic test_reset_defaults();
		// mode none after reset, loads past the store are dropped
		send_tick(PIN_RELEASED, '0, '0);
		send_tick(PIN_PRESSED, '1, '1);
		send_tick(PIN_PRESSED, '0, '0);
		send_load(4'd15, 8'hAB);
		send_load(4'd10, 8'h5A);
		settle();
	endtask

	task automatic test_full_wrap();
		// zero store borrows through all ten bytes, then carries back to zero
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_LEFT_DEC));
		write_reg(CFG_LEN, 4'd10);
		press_button('0, '0);
		send_tick(PIN_PRESSED, '1, '1);
		settle();
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_LEFT_INC));
		press_button('1, '1);
		settle();
	endtask

	task automatic test_right_chain();
		// length zero acts as one byte
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_RIGHT_DEC));
		write_reg(CFG_LEN, 4'd0);
		press_button('0, '0);
		settle();
		// length above the store acts as full length, byte 9 is least significant
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_RIGHT_INC));
		write_reg(CFG_LEN, 4'd15);
		send_load(4'd9, BYTE_ONES);
		send_load(4'd8, 8'h7F);
		send_load(4'd0, BYTE_ZERO);
		press_button('0, '0);
		settle();
	endtask

	task automatic test_random_fill();
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_RANDOM));
		write_reg(CFG_LEN, 4'd10);
		press_button('0, '0);
		press_button('1, '1);
		settle();
	endtask

	task automatic test_cycle_and_unused();
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_CYCLE));
		press_button('1, '0);
		settle();
		write_reg(CFG_MODE, CFG_DATA_W'(ACT_UNUSED));
		press_button('0, '1);
		settle();
	endtask

	task automatic test_random_traffic();
		mode_t phase_modes [8];
		int sent;
		int pick;
		item_t it;
		phase_modes = '{ACT_LEFT_INC, ACT_RIGHT_INC, ACT_LEFT_DEC, ACT_RIGHT_DEC,
			ACT_RANDOM, ACT_CYCLE, ACT_LEFT_INC, ACT_RIGHT_DEC};
		for (int phase = 0; phase < 8; phase++) begin
			settle();
			steady = (phase % 4 == 3);
			write_reg(CFG_MODE, CFG_DATA_W'(phase_modes[phase]));
			if ($urandom_range(0, 3) == 0) write_reg(CFG_LEN, CFG_DATA_W'($urandom_range(0, 15)));
			else write_reg(CFG_LEN, CFG_DATA_W'($urandom_range(1, UID_BYTES)));
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					// bias loads toward 00 and ff so carry chains run long
					case ($urandom_range(0, 3))
						0: it.load_value = BYTE_ONES;
						1: it.load_value = BYTE_ZERO;
						default: it.load_value = BYTE_W'($urandom_range(0, 255));
					endcase
					it.load_index = POS_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 15)
						: $urandom_range(0, UID_BYTES - 1));
					send_load(it.load_index, it.load_value);
					sent++;
				end else if (pick < 8) begin
					press_button({$urandom(), $urandom()}, RHI_W'($urandom_range(0, 65535)));
					sent += 2;
				end else begin
					it = rand_item();
					it.kind = KIND_TICK;
					send_item(it);
					sent++;
				end
			end
		end
		steady = 1'b0;
	endtask

	// result side: random stall before each transaction, none in steady phases
	initial begin
		int stall;
		results.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!(results.valid === 1'b1 && results.ready === 1'b1));
		end
	end

	always @(posedge clk) begin
		uid_result_t want;
		if (arst_n === 1'b1 && results.valid === 1'b1 && results.ready === 1'b1) begin
			if (pending_uid.size() == 0) begin
				report_mismatch($sformatf("unexpected result pos %0d byte %02h",
					results.uid_position, results.uid_byte));
			end else begin
				want = pending_uid.pop_front();
				if (results.uid_position !== want.position)
					report_mismatch($sformatf("uid_position %0d, want %0d",
						results.uid_position, want.position));
				if (results.uid_byte !== want.data)
					report_mismatch($sformatf("uid_byte %02h at pos %0d, want %02h",
						results.uid_byte, want.position, want.data));
				if (results.cycle_request !== want.cycle_req)
					report_mismatch($sformatf("cycle_request %b, want %b",
						results.cycle_request, want.cycle_req));
				if (results.last !== want.last)
					report_mismatch($sformatf("last %b at pos %0d, want %b",
						results.last, want.position, want.last));
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		items.valid <= 1'b0;
		items.kind <= KIND_TICK;
		items.pin_level <= PIN_RELEASED;
		items.load_index <= '0;
		items.load_value <= '0;
		items.random_low <= '0;
		items.random_high <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MODE;
		cfg_data <= '0;
		arst_n <= 1'b0;
		act_mode = ACT_NONE;
		uid_len = 4'd4;
		btn_held = 1'b0;
		foreach (uid_copy[i]) uid_copy[i] = BYTE_ZERO;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_full_wrap();
		test_right_chain();
		test_random_fill();
		test_cycle_and_unused();
		test_random_traffic();
		settle();
		if (err_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule

/* sim.f */
design/bum_pkg.sv
design/bum_if.sv
design/button_uid_modifier_top.sv
tb/tb_top.sv
